// ===== design/mclp_pkg.sv =====
// ----------------------------------------------------------------------------
// mclp_pkg
// Types and character codes shared by the motion command line parser.
// ----------------------------------------------------------------------------
package mclp_pkg;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
    localparam logic [7:0] CHAR_CASE  = 8'h20;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_M     = 8'h4D;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_G     = 8'h47;
    localparam logic [7:0] CHAR_R     = 8'h52;
    localparam logic [7:0] CHAR_D     = 8'h44;

    localparam logic [1:0] KIND_MOVE  = 2'd0;
    localparam logic [1:0] KIND_SPEED = 2'd1;
    localparam logic [1:0] KIND_GRIP  = 2'd2;
    localparam logic [1:0] KIND_HOME  = 2'd3;

    localparam logic [1:0] LAST_SLOT  = 2'd3;

    localparam logic [31:0] INT_MAX_U = 32'h7FFF_FFFF;
    localparam logic [31:0] INT_MIN_U = 32'h8000_0000;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_SIGN,
        PH_DIGITS,
        PH_STOP
    } t_num_phase;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] third_value;
        logic signed [31:0] second_value;
        logic signed [31:0] first_value;
    } t_result;

endpackage

// ===== design/motion_command_line_parser.sv =====
// ----------------------------------------------------------------------------
// motion_command_line_parser
// Decodes text command lines from a serial byte stream into motion commands.
// ----------------------------------------------------------------------------
// Slave channel: one received character per transaction in s_axis_tdata.
// Master channel: one decoded command per transaction; the kind travels in
// m_axis_tuser, the three values in m_axis_tdata.
// A byte is taken in every cycle with s_axis_tready high: the state updates at
// the accepting edge, so the sustained rate is one byte per clock unless the skid
// register is full, set by the single multiply-by-ten-and-add accumulator step.
// A command is shown on the master channel in the cycle after the newline
// transaction that completes it, unless the output register holds a stalled command.
// Results pass through an output register and a one-entry skid register;
// s_axis_tready drops only while the skid register is full, so a stalled
// receiver holds back at most two commands before the byte input stops.
// Reset (synchronous, active low) empties both result registers, clears the
// current line and the pending coordinate flag.
// Lines longer than LINE_CHARS keep only their first LINE_CHARS characters.
// ----------------------------------------------------------------------------
module motion_command_line_parser
    import mclp_pkg::*;
#(
    parameter int LINE_CHARS = 19
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [7:0] rx_byte
    input  logic [7:0]   s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] first_value, [63:32] second_value, [95:64] third_value
    output logic [95:0]  m_axis_tdata,
    // [1:0] command_kind
    output logic [1:0]   m_axis_tuser
);

    localparam int CW = $clog2(LINE_CHARS + 1);
    localparam logic [CW-1:0] KEEP_MAX = CW'(LINE_CHARS);

    logic [CW-1:0] r_kept, n_kept;
    logic [7:0]    r_head, n_head;
    logic          r_await, n_await;
    logic [1:0]    r_slot, n_slot;
    t_num_phase    r_phase, n_phase;
    logic          r_neg, n_neg;
    logic          r_ovf, n_ovf;
    logic [31:0]   r_acc [3];
    logic [31:0]   n_acc [3];

    t_result r_out, r_skid, res;
    logic    r_out_valid, r_skid_valid;
    logic    accept, push, out_fire;

    logic [7:0]  cu;
    logic        is_digit, is_blank, is_sign;
    logic [31:0] cur_acc, fin;
    logic [35:0] prod;
    logic [31:0] v0, v1, v2;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_fire = r_out_valid && m_axis_tready;

    always_comb begin
        cu = s_axis_tdata;
        if (s_axis_tdata >= CHAR_LOW_A && s_axis_tdata <= CHAR_LOW_Z) begin
            cu = s_axis_tdata - CHAR_CASE;
        end
        is_digit = (cu >= CHAR_ZERO) && (cu <= CHAR_NINE);
        is_blank = (cu == CHAR_SPACE) || (cu == CHAR_TAB) || (cu == CHAR_VT)
                   || (cu == CHAR_FF);
        is_sign  = (cu == CHAR_PLUS) || (cu == CHAR_MINUS);
    end

    // magnitude of the number in progress and its saturated final value
    always_comb begin
        case (r_slot)
            2'd0:    cur_acc = r_acc[0];
            2'd1:    cur_acc = r_acc[1];
            2'd2:    cur_acc = r_acc[2];
            default: cur_acc = '0;
        endcase
        prod = ({4'b0, cur_acc} << 3) + ({4'b0, cur_acc} << 1)
               + {32'b0, cu[3:0] - CHAR_ZERO[3:0]};
        if (r_neg) begin
            fin = r_ovf ? INT_MIN_U : (32'd0 - cur_acc);
        end else begin
            fin = (r_ovf || cur_acc[31]) ? INT_MAX_U : cur_acc;
        end
    end

    // parser next state
    always_comb begin
        n_kept  = r_kept;
        n_head  = r_head;
        n_await = r_await;
        n_slot  = r_slot;
        n_phase = r_phase;
        n_neg   = r_neg;
        n_ovf   = r_ovf;
        n_acc   = r_acc;
        if (accept) begin
            if (cu == CHAR_LF) begin
                if (r_kept != '0 && r_head != CHAR_NUL) begin
                    if (r_await) begin
                        n_await = 1'b0;
                    end else if (r_head == CHAR_D) begin
                        n_await = 1'b1;
                    end
                end
                n_kept  = '0;
                n_head  = CHAR_NUL;
                n_slot  = '0;
                n_phase = PH_SKIP;
                n_neg   = 1'b0;
                n_ovf   = 1'b0;
                n_acc   = '{3{32'd0}};
            end else if (r_kept < KEEP_MAX && cu != CHAR_CR) begin
                if (r_kept == '0) begin
                    n_head = cu;
                end
                if ((r_await || r_kept != '0) && r_phase != PH_STOP) begin
                    if (cu == CHAR_NUL) begin
                        if (r_phase == PH_DIGITS) begin
                            n_acc[r_slot] = fin;
                            n_neg         = 1'b0;
                            n_ovf         = 1'b0;
                            n_slot        = r_slot + 2'd1;
                        end
                        n_phase = PH_STOP;
                    end else if (is_digit) begin
                        if (prod > {4'b0, INT_MIN_U}) begin
                            n_ovf         = 1'b1;
                            n_acc[r_slot] = INT_MIN_U;
                        end else begin
                            n_acc[r_slot] = prod[31:0];
                        end
                        n_phase = PH_DIGITS;
                    end else if (r_phase == PH_DIGITS) begin
                        // number ends here, this character may open the next one
                        n_acc[r_slot] = fin;
                        n_ovf         = 1'b0;
                        n_slot        = r_slot + 2'd1;
                        n_neg         = 1'b0;
                        if (r_slot + 2'd1 == LAST_SLOT) begin
                            n_phase = PH_STOP;
                        end else if (is_blank) begin
                            n_phase = PH_SKIP;
                        end else if (is_sign) begin
                            n_neg   = (cu == CHAR_MINUS);
                            n_phase = PH_SIGN;
                        end else begin
                            n_phase = PH_STOP;
                        end
                    end else if (r_phase == PH_SKIP) begin
                        if (is_sign) begin
                            n_neg   = (cu == CHAR_MINUS);
                            n_phase = PH_SIGN;
                        end else if (!is_blank) begin
                            n_phase = PH_STOP;
                        end
                    end else begin
                        n_phase = PH_STOP;
                    end
                end
                n_kept = r_kept + CW'(1);
            end
        end
    end

    // result of a completed line
    always_comb begin
        v0 = (r_phase == PH_DIGITS && r_slot == 2'd0) ? fin : r_acc[0];
        v1 = (r_phase == PH_DIGITS && r_slot == 2'd1) ? fin : r_acc[1];
        v2 = (r_phase == PH_DIGITS && r_slot == 2'd2) ? fin : r_acc[2];
        res  = '0;
        push = 1'b0;
        if (accept && cu == CHAR_LF && r_kept != '0 && r_head != CHAR_NUL) begin
            push = 1'b1;
            res.first_value  = v0;
            res.second_value = v1;
            res.third_value  = v2;
            if (r_await || r_head == CHAR_M) begin
                res.kind = KIND_MOVE;
            end else if (r_head == CHAR_S) begin
                res.kind = KIND_SPEED;
            end else if (r_head == CHAR_G) begin
                res.kind         = KIND_GRIP;
                res.second_value = '0;
                res.third_value  = '0;
            end else if (r_head == CHAR_R) begin
                res.kind         = KIND_HOME;
                res.first_value  = '0;
                res.second_value = '0;
                res.third_value  = '0;
            end else begin
                push = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept  <= '0;
            r_head  <= CHAR_NUL;
            r_await <= 1'b0;
            r_slot  <= '0;
            r_phase <= PH_SKIP;
            r_neg   <= 1'b0;
            r_ovf   <= 1'b0;
            r_acc   <= '{3{32'd0}};
        end else begin
            r_kept  <= n_kept;
            r_head  <= n_head;
            r_await <= n_await;
            r_slot  <= n_slot;
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_ovf   <= n_ovf;
            r_acc   <= n_acc;
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || out_fire) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    assign s_axis_tready = !r_skid_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {r_out.third_value, r_out.second_value, r_out.first_value};

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_last_slot_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot == LAST_SLOT) |-> (r_phase == PH_STOP))
        else $error("number parsing continues past the third value");

    a_push_on_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (accept && s_axis_tdata == CHAR_LF))
        else $error("command produced without a newline");

    a_kept_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept <= KEEP_MAX)
        else $error("kept character count beyond line length");

    a_newline_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s_axis_tdata == CHAR_LF) |=> (r_kept == '0 && r_slot == '0))
        else $error("line state not cleared after newline");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives serial bytes into motion_command_line_parser. A directed table of
// command lines is followed by random lines and noise. Each command that comes
// out is checked field by field against the table or a cycle-free software copy
// of the parser, with idling on both sides and one long receiver stall.
// ----------------------------------------------------------------------------
module testbench
    import mclp_pkg::*;
();

    localparam int LINE_CHARS      = 19;
    localparam int RANDOM_BYTES    = 320;
    localparam int PRESSURE_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 10;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int REPORT_LIMIT    = 10;

    typedef logic [7:0] t_bytes[$];

    typedef struct {
        string   text;
        int      nul_at;
        bit      typed;
        t_result want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [7:0] rx_byte
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [31:0] first_value, [63:32] second_value, [95:64] third_value
    logic [95:0] m_axis_tdata;
    // [1:0] command_kind
    logic [1:0]  m_axis_tuser;

    t_result pending_commands[$];
    int      fail_count = 0;
    int      cycle_count = 0;
    int      tx_idle_pct = 0;
    int      rx_idle_pct = 0;
    logic    pressure_go = 1'b0;
    bit      pressure_done = 1'b0;

    // shadow parser state
    int unsigned line_len;
    logic [7:0]  line_first;
    bit          coords_armed;
    logic [1:0]  num_index;
    t_num_phase  num_phase;
    bit          num_minus;
    bit          num_saturated;
    logic [31:0] num_acc [3];

    motion_command_line_parser #(
        .LINE_CHARS(LINE_CHARS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    function automatic t_result make_cmd(logic [1:0] kind, logic signed [31:0] a,
                                         logic signed [31:0] b, logic signed [31:0] c);
        t_result r;
        r.kind         = kind;
        r.first_value  = a;
        r.second_value = b;
        r.third_value  = c;
        return r;
    endfunction

    function automatic void clear_line();
        line_len      = 0;
        line_first    = CHAR_NUL;
        num_index     = 2'd0;
        num_phase     = PH_SKIP;
        num_minus     = 1'b0;
        num_saturated = 1'b0;
        foreach (num_acc[k]) num_acc[k] = 32'd0;
    endfunction

    function automatic void close_number();
        logic [31:0] mag;
        if (num_index != LAST_SLOT) begin
            mag = num_acc[num_index];
            if (num_minus)
                num_acc[num_index] = num_saturated ? INT_MIN_U : 32'd0 - mag;
            else
                num_acc[num_index] = (num_saturated || mag > INT_MAX_U) ? INT_MAX_U : mag;
            num_index = num_index + 2'd1;
        end
        num_minus     = 1'b0;
        num_saturated = 1'b0;
        num_phase     = (num_index == LAST_SLOT) ? PH_STOP : PH_SKIP;
    endfunction

    function automatic void take_number_char(logic [7:0] ch);
        bit          is_digit;
        logic [63:0] grown;
        is_digit = (ch >= CHAR_ZERO && ch <= CHAR_NINE);
        if (num_phase == PH_STOP) return;
        if (ch == CHAR_NUL) begin
            if (num_phase == PH_DIGITS) close_number();
            num_phase = PH_STOP;
            return;
        end
        if (num_phase == PH_DIGITS && !is_digit) close_number();
        if (num_phase == PH_STOP) return;
        if (is_digit) begin
            if (num_index != LAST_SLOT) begin
                grown = 64'(num_acc[num_index]) * 64'd10 + 64'(ch - CHAR_ZERO);
                if (grown > 64'(INT_MIN_U)) begin
                    num_saturated = 1'b1;
                    grown = 64'(INT_MIN_U);
                end
                num_acc[num_index] = grown[31:0];
            end
            num_phase = PH_DIGITS;
            return;
        end
        if (num_phase == PH_SKIP) begin
            if (ch == CHAR_SPACE || ch == CHAR_TAB || ch == CHAR_VT || ch == CHAR_FF) return;
            if (ch == CHAR_PLUS || ch == CHAR_MINUS) begin
                num_minus = (ch == CHAR_MINUS);
                num_phase = PH_SIGN;
                return;
            end
        end
        num_phase = PH_STOP;
    endfunction

    // advances the shadow parser by one byte, got is set when a command results
    function automatic void parse_byte(logic [7:0] rx, output bit got, output t_result cmd);
        logic [7:0] ch;
        ch  = rx;
        got = 1'b0;
        cmd = '0;
        if (ch == CHAR_LF) begin
            if (line_len > 0 && line_first != CHAR_NUL) begin
                if (num_phase == PH_DIGITS) close_number();
                cmd = make_cmd(KIND_MOVE, num_acc[0], num_acc[1], num_acc[2]);
                got = 1'b1;
                if (coords_armed) begin
                    coords_armed = 1'b0;
                end else if (line_first == CHAR_M) begin
                    cmd.kind = KIND_MOVE;
                end else if (line_first == CHAR_S) begin
                    cmd.kind = KIND_SPEED;
                end else if (line_first == CHAR_G) begin
                    cmd = make_cmd(KIND_GRIP, num_acc[0], 32'sd0, 32'sd0);
                end else if (line_first == CHAR_R) begin
                    cmd = make_cmd(KIND_HOME, 32'sd0, 32'sd0, 32'sd0);
                end else begin
                    got = 1'b0;
                    if (line_first == CHAR_D) coords_armed = 1'b1;
                end
            end
            clear_line();
            return;
        end
        if (line_len >= LINE_CHARS || ch == CHAR_CR) return;
        if (ch >= CHAR_LOW_A && ch <= CHAR_LOW_Z) ch = ch - CHAR_CASE;
        if (line_len == 0) line_first = ch;
        if (coords_armed || line_len >= 1) take_number_char(ch);
        line_len++;
    endfunction

    task automatic send_byte(input logic [7:0] rx, output bit got, output t_result cmd);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx;
        do @(posedge i_clk); while (!s_axis_tready);
        parse_byte(rx, got, cmd);
    endtask

    function automatic logic [7:0] random_blank();
        case ($urandom_range(3))
            0:       return CHAR_SPACE;
            1:       return CHAR_TAB;
            2:       return CHAR_VT;
            default: return CHAR_FF;
        endcase
    endfunction

    // mostly well-formed lines with random numbers, some noise and some corrupted
    function automatic t_bytes random_line();
        t_bytes            q;
        string             heads = "MSGRD";
        string             digits;
        logic [7:0]        ch;
        longint unsigned   mag;
        int                style;
        int                n_numbers;
        style = $urandom_range(99);
        if (style < 12) begin
            repeat ($urandom_range(24)) q.push_back(8'($urandom_range(255)));
        end else begin
            ch = heads[$urandom_range(4)];
            if ($urandom_range(2) == 0) ch = ch + CHAR_CASE;
            q.push_back(ch);
            n_numbers = $urandom_range(3);
            for (int k = 0; k < n_numbers; k++) begin
                repeat ($urandom_range(2)) q.push_back(random_blank());
                case ($urandom_range(3))
                    0:       q.push_back(CHAR_MINUS);
                    1:       q.push_back(CHAR_PLUS);
                    default: ;
                endcase
                case ($urandom_range(11))
                    0:          mag = 0;
                    1:          mag = 64'd2147483647;
                    2:          mag = 64'd2147483648;
                    3:          mag = 64'd4294967295;
                    4:          mag = 64'd99999999999;
                    5, 6, 7, 8: mag = $urandom_range(999);
                    default:    mag = $urandom;
                endcase
                digits = $sformatf("%0d", mag);
                foreach (digits[i]) q.push_back(digits[i]);
            end
            if (style >= 88) q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
            if ($urandom_range(9) == 0) q.insert($urandom_range(q.size()), CHAR_CR);
        end
        q.push_back(CHAR_LF);
        return q;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
    endtask

    task automatic check_command();
        t_result want;
        if (pending_commands.size() == 0) begin
            note_failure($sformatf("command with none pending: kind %0d data %h",
                                   m_axis_tuser, m_axis_tdata));
            return;
        end
        want = pending_commands.pop_front();
        if (m_axis_tuser !== want.kind ||
            m_axis_tdata[31:0] !== want.first_value ||
            m_axis_tdata[63:32] !== want.second_value ||
            m_axis_tdata[95:64] !== want.third_value)
            note_failure($sformatf(
                "expected kind %0d values %0d %0d %0d, got kind %0d values %0d %0d %0d",
                want.kind, want.first_value, want.second_value, want.third_value,
                m_axis_tuser, $signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]),
                $signed(m_axis_tdata[95:64])));
    endtask

    initial begin : command_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) check_command();
            if (pressure_go && !pressure_done) begin
                hold_left     = PRESSURE_CYCLES;
                pressure_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("motion_command_line_parser test failed");
        $finish;
    end

    initial begin : stimulus
        t_dir_row rows[$];
        t_bytes   line;
        t_result  cmd;
        bit       got;
        int       sent_random;
        clear_line();
        coords_armed = 1'b0;
        tx_idle_pct  = 31;
        rx_idle_pct  = 72;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows.push_back('{"m 100 -200 +300\n", -1, 1'b1, make_cmd(KIND_MOVE, 100, -200, 300)});
        rows.push_back('{"S2147483648 -9\n", -1, 1'b1, make_cmd(KIND_SPEED, INT_MAX_U, -9, 0)});
        rows.push_back('{"M-99999999999\0111\n", -1, 1'b1, make_cmd(KIND_MOVE, INT_MIN_U, 1, 0)});
        rows.push_back('{"G 1\n", -1, 1'b1, make_cmd(KIND_GRIP, 1, 0, 0)});
        rows.push_back('{"r 5 6 7\n", -1, 1'b1, make_cmd(KIND_HOME, 0, 0, 0)});
        rows.push_back('{"D\n", -1, 1'b0, '0});
        rows.push_back('{"-5 +7 8\015\n", -1, 1'b1, make_cmd(KIND_MOVE, -5, 7, 8)});
        rows.push_back('{"\n", -1, 1'b0, '0});
        rows.push_back('{"Q 1\n", -1, 1'b0, '0});
        rows.push_back('{"M 1 2 345678901234567890\n", -1, 1'b0, '0});
        rows.push_back('{"M 5\n", 0, 1'b0, '0});
        rows.push_back('{"M 5 6\n", 4, 1'b0, '0});
        rows.push_back('{"S 1\3772\n", -1, 1'b0, '0});
        rows.push_back('{"M+ 3 4\n", -1, 1'b0, '0});
        rows.push_back('{"M 1-2+3\n", -1, 1'b1, make_cmd(KIND_MOVE, 1, -2, 3)});
        rows.push_back('{"S\0137\0148 9\n", -1, 1'b1, make_cmd(KIND_SPEED, 7, 8, 9)});
        rows.push_back('{"d\n", -1, 1'b0, '0});
        rows.push_back('{"\n", -1, 1'b0, '0});
        rows.push_back('{"R\n", -1, 1'b0, '0});
        rows.push_back('{"M 4294967295 -0\n", -1, 1'b1, make_cmd(KIND_MOVE, INT_MAX_U, 0, 0)});
        rows.push_back('{"m -2147483648\n", -1, 1'b1, make_cmd(KIND_MOVE, INT_MIN_U, 0, 0)});
        rows.push_back('{"g -1 9\n", -1, 1'b1, make_cmd(KIND_GRIP, -1, 0, 0)});
        rows.push_back('{"m\n", -1, 1'b1, make_cmd(KIND_MOVE, 0, 0, 0)});

        foreach (rows[r]) begin
            for (int i = 0; i < rows[r].text.len(); i++) begin
                if (i == rows[r].nul_at) send_byte(CHAR_NUL, got, cmd);
                send_byte(rows[r].text[i], got, cmd);
                if (got) pending_commands.push_back(rows[r].typed ? rows[r].want : cmd);
            end
        end

        sent_random = 0;
        while (sent_random < RANDOM_BYTES) begin
            if (sent_random >= 2 * RANDOM_BYTES / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                pressure_go <= 1'b1;
            end else if (sent_random >= RANDOM_BYTES / 3) begin
                tx_idle_pct = 72;
                rx_idle_pct = 31;
            end
            line = random_line();
            foreach (line[i]) begin
                send_byte(line[i], got, cmd);
                if (got) pending_commands.push_back(cmd);
            end
            sent_random += line.size();
        end
        s_axis_tvalid <= 1'b0;

        while (pending_commands.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("motion_command_line_parser test passed");
        else
            $display("motion_command_line_parser test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mclp_pkg.sv
design/motion_command_line_parser.sv
bench/testbench.sv
